>>> hw/rtl/ntage_pkg.sv
// Shared types and constants for the neighbour table with aging.
package ntage_pkg;

	localparam int unsigned AddrW            = 32;
	localparam int unsigned PortW            = 2;
	localparam int unsigned AgeW             = 16;
	localparam int unsigned CountW           = 5;
	localparam int unsigned CountMax         = 31;
	localparam int unsigned NeighborsDefault = 16;
	localparam int unsigned NbrPorts         = 4;
	localparam logic [AgeW-1:0] DeadTicksReset = AgeW'(15);
	localparam logic [AgeW-1:0] AgeMax         = {AgeW{1'b1}};

	typedef logic [AddrW-1:0]  addr_t;
	typedef logic [PortW-1:0]  port_t;
	typedef logic [AgeW-1:0]   age_t;
	typedef logic [CountW-1:0] count_t;

	typedef enum logic {
		ModeHello = 1'b0,
		ModeTick  = 1'b1
	} mode_t;

	typedef struct packed {
		port_t port;
		addr_t addr;
		addr_t router;
		addr_t mask;
	} entry_t;

endpackage

>>> hw/rtl/neighbor_table_with_aging.sv
// Top level of the neighbour table with dead-interval aging.
// The block takes one hello or tick item on every clock cycle in which start is high; busy
// never rises. Each item gives one result on done. While the item sits in the input register,
// it is matched against the whole table, and the table flip-flops are updated as it leaves
// that register. The valid entries are then counted into the result register, which drives
// done and the result ports. Results follow each other at the input rate and the receiver
// cannot stall them. A dead_ticks write is taken on cfg_valid while no item sits in the input
// register.
module neighbor_table_with_aging #(
	parameter int unsigned NEIGHBORS = ntage_pkg::NeighborsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  ntage_pkg::port_t   port,
	input  ntage_pkg::addr_t   src_addr,
	input  ntage_pkg::addr_t   router_ident,
	input  ntage_pkg::addr_t   net_mask,
	output logic               done,
	output logic               changed,
	output logic               dropped,
	output ntage_pkg::count_t  neighbor_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  ntage_pkg::age_t    cfg_data
);
	import ntage_pkg::*;

	localparam int unsigned PopW = $clog2(NEIGHBORS + 1);

	// Input register
	logic   valid_s1;
	logic   mode_s1;
	entry_t item_s1;

	// Table
	logic [NEIGHBORS-1:0] valid_q;
	entry_t               entry_q [NEIGHBORS];
	age_t                 age_q   [NEIGHBORS];
	age_t                 dead_ticks_q;

	// Update stage outputs
	logic valid_s2;
	logic changed_s2;
	logic dropped_s2;

	// Result register
	logic   done_q;
	logic   changed_q;
	logic   dropped_q;
	count_t count_q;

	logic [NEIGHBORS-1:0] hit_v;
	logic [NEIGHBORS-1:0] free_v;
	logic [NEIGHBORS-1:0] ins_oh;
	logic [NEIGHBORS-1:0] valid_d;
	age_t                 age_d [NEIGHBORS];
	logic                 port_ok;
	logic                 chg_d;
	logic                 drp_d;
	logic [PopW-1:0]      pop;
	count_t               count_d;

	assign busy      = 1'b0;
	assign cfg_ready = ~valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_ticks_q <= DeadTicksReset;
		end else if (cfg_valid && cfg_ready) begin
			dead_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1        <= mode;
			item_s1.port   <= port;
			item_s1.addr   <= src_addr;
			item_s1.router <= router_ident;
			item_s1.mask   <= net_mask;
		end
	end

	assign port_ok = 32'(item_s1.port) < 32'(NbrPorts);

	always_comb begin
		for (int i = 0; i < NEIGHBORS; i++) begin
			hit_v[i] = valid_q[i] && (entry_q[i].port == item_s1.port)
				&& (entry_q[i].addr == item_s1.addr);
		end
		free_v = ~valid_q;
	end

	// Lowest free entry as a one-hot vector.
	assign ins_oh = free_v & (~free_v + NEIGHBORS'(1));

	always_comb begin
		valid_d = valid_q;
		chg_d   = 1'b0;
		drp_d   = 1'b0;
		for (int i = 0; i < NEIGHBORS; i++) begin
			age_d[i] = age_q[i];
		end
		if (valid_s1) begin
			if (mode_s1 == ModeTick) begin
				for (int i = 0; i < NEIGHBORS; i++) begin
					if (valid_q[i]) begin
						if (age_q[i] > dead_ticks_q) begin
							valid_d[i] = 1'b0;
							chg_d      = 1'b1;
						end else if (age_q[i] != AgeMax) begin
							age_d[i] = age_q[i] + AgeW'(1);
						end
					end
				end
			end else if (port_ok) begin
				if (|hit_v) begin
					for (int i = 0; i < NEIGHBORS; i++) begin
						if (hit_v[i]) begin
							age_d[i] = '0;
						end
					end
				end else if (|free_v) begin
					valid_d = valid_q | ins_oh;
					chg_d   = 1'b1;
					for (int i = 0; i < NEIGHBORS; i++) begin
						if (ins_oh[i]) begin
							age_d[i] = '0;
						end
					end
				end else begin
					drp_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_q  <= valid_d;
			valid_s2 <= valid_s1;
		end
	end

	// Entry contents are written only when an entry is taken.
	always_ff @(posedge clk) begin
		changed_s2 <= chg_d;
		dropped_s2 <= drp_d;
		for (int i = 0; i < NEIGHBORS; i++) begin
			age_q[i] <= age_d[i];
			if (valid_s1 && (mode_s1 == ModeHello) && port_ok && !(|hit_v) && ins_oh[i]) begin
				entry_q[i] <= item_s1;
			end
		end
	end

	// The table already holds this item's outcome while the next item is being matched.
	always_comb begin
		pop = '0;
		for (int i = 0; i < NEIGHBORS; i++) begin
			pop = pop + PopW'(valid_q[i]);
		end
		if (32'(pop) > 32'(CountMax)) begin
			count_d = CountW'(CountMax);
		end else begin
			count_d = CountW'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			changed_q <= changed_s2;
			dropped_q <= dropped_s2;
			count_q   <= count_d;
		end
	end

	assign done           = done_q;
	assign changed        = changed_q;
	assign dropped        = dropped_q;
	assign neighbor_count = count_q;

endmodule
